/* design/sector_cache_lfu_policy_unit_macros.svh */
// assertion macros for the sector cache policy unit
`ifndef SECTOR_CACHE_LFU_POLICY_UNIT_MACROS_SVH
`define SECTOR_CACHE_LFU_POLICY_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SCLFU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// same-cycle implication
`define SCLFU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCLFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sclfu_pkg.sv */
package sclfu_pkg;

    localparam int ENTRIES_DEF = 15;
    localparam int SECTOR_LIMIT = 65536;
    localparam int SECTOR_W = 16;
    localparam int PRIO_W = 8;
    localparam int SLOT_W_MIN = 4;

    localparam logic [SECTOR_W:0] SECTOR_LIMIT_V = (SECTOR_W + 1)'(SECTOR_LIMIT);
    localparam logic [PRIO_W-1:0] INIT_PRIO_RESET = 8'd5;
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    typedef enum logic [1:0] {
        ST_HIT    = 2'd0,
        ST_FILL   = 2'd1,
        ST_EVICT  = 2'd2,
        ST_REJECT = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic reject;
    } t_dp_stat;

    function automatic int idx_w(input int entries);
        return (entries > 1) ? $clog2(entries) : 1;
    endfunction

    function automatic int slot_w(input int entries);
        return (idx_w(entries) > SLOT_W_MIN) ? idx_w(entries) : SLOT_W_MIN;
    endfunction

endpackage

/* design/sector_cache_lfu_policy_unit.sv */
// Tag and least-frequently-used replacement engine for a small sector cache. Each item is a
// read or write request for a sector; the result gives hit, fill of a free slot, eviction
// (with the victim sector for write-back) or rejection of sector zero and sectors at or above
// the limit. Hits raise an entry's priority by one up to 255; new entries start at the
// initial priority register (reset 5), to be written through i_cfg_we/i_cfg_data only while
// idle, which the block itself does not enforce. One item is in work at a time: the entry
// table has a single read port and is scanned one entry per cycle; a rejected sector skips
// the scan. The result sits in an output register; the next item is accepted while it waits,
// and only the final commit cycle stalls until that register is free.
module sector_cache_lfu_policy_unit #(
    parameter int ENTRIES = sclfu_pkg::ENTRIES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sclfu_pkg::PRIO_W-1:0]           i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_op,
    input  logic [sclfu_pkg::SECTOR_W-1:0]         i_sector,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [1:0]                             o_status,
    output logic [sclfu_pkg::slot_w(ENTRIES)-1:0]  o_slot,
    output logic                                   o_fetch_needed,
    output logic                                   o_writeback_needed,
    output logic [sclfu_pkg::SECTOR_W-1:0]         o_victim_sector
);
    import sclfu_pkg::*;

    localparam int IDX_W = idx_w(ENTRIES);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [IDX_W-1:0] idx;

    sclfu_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    sclfu_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_op               (i_op),
        .i_sector           (i_sector),
        .i_cmd              (cmd),
        .i_idx              (idx),
        .o_stat             (stat),
        .o_status           (o_status),
        .o_slot             (o_slot),
        .o_fetch_needed     (o_fetch_needed),
        .o_writeback_needed (o_writeback_needed),
        .o_victim_sector    (o_victim_sector)
    );

endmodule

/* design/sclfu_ctrl.sv */
module sclfu_ctrl #(
    parameter int ENTRIES = sclfu_pkg::ENTRIES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    input  sclfu_pkg::t_dp_stat                    i_stat,
    output sclfu_pkg::t_dp_cmd                     o_cmd,
    output logic [sclfu_pkg::idx_w(ENTRIES)-1:0]   o_idx
);
    import sclfu_pkg::*;

    localparam int IDX_W = idx_w(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic              accept;
    logic              out_free;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (i_stat.reject || (r_idx == LAST_IDX)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == S_COMMIT) && out_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.start  = accept;
    assign o_cmd.scan   = (r_state == S_SCAN) && !i_stat.reject;
    assign o_cmd.commit = (r_state == S_COMMIT) && out_free;
    assign o_idx        = r_idx;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;

endmodule

/* design/sclfu_dp.sv */
module sclfu_dp #(
    parameter int ENTRIES = sclfu_pkg::ENTRIES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sclfu_pkg::PRIO_W-1:0]           i_cfg_data,
    input  logic                                   i_op,
    input  logic [sclfu_pkg::SECTOR_W-1:0]         i_sector,
    input  sclfu_pkg::t_dp_cmd                     i_cmd,
    input  logic [sclfu_pkg::idx_w(ENTRIES)-1:0]   i_idx,
    output sclfu_pkg::t_dp_stat                    o_stat,
    output logic [1:0]                             o_status,
    output logic [sclfu_pkg::slot_w(ENTRIES)-1:0]  o_slot,
    output logic                                   o_fetch_needed,
    output logic                                   o_writeback_needed,
    output logic [sclfu_pkg::SECTOR_W-1:0]         o_victim_sector
);
    import sclfu_pkg::*;

    localparam int IDX_W  = idx_w(ENTRIES);
    localparam int SLOT_W = slot_w(ENTRIES);

    // entry table
    logic [ENTRIES-1:0]  r_valid;
    logic [SECTOR_W-1:0] r_sector [ENTRIES];
    logic [PRIO_W-1:0]   r_prio   [ENTRIES];
    logic [PRIO_W-1:0]   r_init_prio;

    // request and scan results
    logic                r_op;
    logic [SECTOR_W-1:0] r_req;
    logic                r_reject;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_slot;
    logic [PRIO_W-1:0]   r_hit_prio;
    logic                r_free;
    logic [IDX_W-1:0]    r_free_slot;
    logic [PRIO_W-1:0]   r_min_prio;
    logic [IDX_W-1:0]    r_min_slot;
    logic [SECTOR_W-1:0] r_min_sector;

    // result register
    t_status             r_status;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_fetch;
    logic                r_wb;
    logic [SECTOR_W-1:0] r_victim;

    logic                reject_in;
    logic                rd_valid;
    logic [SECTOR_W-1:0] rd_sector;
    logic [PRIO_W-1:0]   rd_prio;

    t_status             res_status;
    logic [IDX_W-1:0]    wr_slot;
    logic                wr_fill;
    logic                wr_prio;
    logic [PRIO_W-1:0]   wr_prio_val;
    logic [SLOT_W-1:0]   res_slot;
    logic                res_fetch;
    logic                res_wb;
    logic [SECTOR_W-1:0] res_victim;

    assign reject_in = (i_sector == '0) || ({1'b0, i_sector} >= SECTOR_LIMIT_V);

    assign rd_valid  = r_valid[i_idx];
    assign rd_sector = r_sector[i_idx];
    assign rd_prio   = r_prio[i_idx];

    always_comb begin
        res_status  = ST_REJECT;
        wr_slot     = '0;
        wr_fill     = 1'b0;
        wr_prio     = 1'b0;
        wr_prio_val = r_init_prio;
        res_slot    = '0;
        res_fetch   = 1'b0;
        res_wb      = 1'b0;
        res_victim  = '0;
        if (!r_reject) begin
            if (r_hit) begin
                res_status  = ST_HIT;
                wr_slot     = r_hit_slot;
                wr_prio     = 1'b1;
                wr_prio_val = (r_hit_prio == PRIO_MAX) ? PRIO_MAX : r_hit_prio + 1'b1;
            end else begin
                wr_fill   = 1'b1;
                wr_prio   = 1'b1;
                res_fetch = !r_op;
                if (r_free) begin
                    res_status = ST_FILL;
                    wr_slot    = r_free_slot;
                end else begin
                    res_status = ST_EVICT;
                    wr_slot    = r_min_slot;
                    res_wb     = 1'b1;
                    res_victim = r_min_sector;
                end
            end
            res_slot = SLOT_W'(wr_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_init_prio <= INIT_PRIO_RESET;
        end else begin
            if (i_cfg_we) begin
                r_init_prio <= i_cfg_data;
            end
            if (i_cmd.commit && wr_fill) begin
                r_valid[wr_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_op;
            r_req    <= i_sector;
            r_reject <= reject_in;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
        end
        if (i_cmd.scan) begin
            if (rd_valid && (rd_sector == r_req) && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_slot <= i_idx;
                r_hit_prio <= rd_prio;
            end
            if (!rd_valid && !r_free) begin
                r_free      <= 1'b1;
                r_free_slot <= i_idx;
            end
            // first lowest priority wins a tie
            if ((i_idx == '0) || (rd_prio < r_min_prio)) begin
                r_min_prio   <= rd_prio;
                r_min_slot   <= i_idx;
                r_min_sector <= rd_sector;
            end
        end
        if (i_cmd.commit) begin
            r_status <= res_status;
            r_slot   <= res_slot;
            r_fetch  <= res_fetch;
            r_wb     <= res_wb;
            r_victim <= res_victim;
            if (wr_fill) begin
                r_sector[wr_slot] <= r_req;
            end
            if (wr_prio) begin
                r_prio[wr_slot] <= wr_prio_val;
            end
        end
    end

    assign o_stat.reject      = r_reject;
    assign o_status           = r_status;
    assign o_slot             = r_slot;
    assign o_fetch_needed     = r_fetch;
    assign o_writeback_needed = r_wb;
    assign o_victim_sector    = r_victim;

endmodule

/* design/sclfu_checker.sv */
`include "sector_cache_lfu_policy_unit_macros.svh"

module sclfu_checker #(
    parameter int ENTRIES = sclfu_pkg::ENTRIES_DEF
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic [1:0]                             o_status,
    input logic [sclfu_pkg::slot_w(ENTRIES)-1:0]  o_slot,
    input logic                                   o_fetch_needed,
    input logic                                   o_writeback_needed,
    input logic [sclfu_pkg::SECTOR_W-1:0]         o_victim_sector
);
    import sclfu_pkg::*;

    // write-back flagged exactly on eviction, victim zero otherwise
    `SCLFU_ASSERT_IMPLIES(a_wb_evict, o_out_valid, (o_writeback_needed == (o_status == ST_EVICT)) && (o_writeback_needed || (o_victim_sector == '0)), "write-back flag does not match eviction")

    // rejected item carries no slot, fetch or victim
    `SCLFU_ASSERT_IMPLIES(a_reject_zero, o_out_valid && (o_status == ST_REJECT), (o_slot == '0) && !o_fetch_needed && !o_writeback_needed && (o_victim_sector == '0), "rejected item has nonzero fields")

    // fetch only on a miss
    `SCLFU_ASSERT_IMPLIES(a_fetch_miss, o_out_valid && o_fetch_needed, (o_status == ST_FILL) || (o_status == ST_EVICT), "fetch requested without a miss")

    // one item in work at a time
    `SCLFU_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "item accepted while previous in work")

    // stalled result holds
    `SCLFU_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_slot) && $stable(o_victim_sector), "stalled result changed")

endmodule

bind sector_cache_lfu_policy_unit sclfu_checker #(.ENTRIES(ENTRIES)) u_sclfu_checker (.*);
